// File: hw/rtl/mse_pkg.sv
// Shared types and constants of the MIPS integer-subset execute core.
// Used by mips_subset_instruction_executor_core; no other dependencies.
package mse_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned NumRegs  = 32;
  localparam int unsigned RegAddrW = 5;
  localparam int unsigned CfgIdxW  = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgStartPc  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgStackTop = 1'b1;

  // Architectural register numbers with a fixed role.
  localparam logic [RegAddrW-1:0] RegZero = 5'd0;
  localparam logic [RegAddrW-1:0] RegSp   = 5'd29;
  localparam logic [RegAddrW-1:0] RegRa   = 5'd31;

  // Primary opcodes.
  localparam logic [5:0] OpSpecial  = 6'h00;
  localparam logic [5:0] OpJ        = 6'h02;
  localparam logic [5:0] OpJal      = 6'h03;
  localparam logic [5:0] OpBeq      = 6'h04;
  localparam logic [5:0] OpBne      = 6'h05;
  localparam logic [5:0] OpAddi     = 6'h08;
  localparam logic [5:0] OpAddiu    = 6'h09;
  localparam logic [5:0] OpOri      = 6'h0D;
  localparam logic [5:0] OpLui      = 6'h0F;
  localparam logic [5:0] OpSpecial2 = 6'h1C;
  localparam logic [5:0] OpLw       = 6'h23;
  localparam logic [5:0] OpSw       = 6'h2B;

  // Function codes.
  localparam logic [5:0] FnSll  = 6'h00;
  localparam logic [5:0] FnMul  = 6'h02;
  localparam logic [5:0] FnJr   = 6'h08;
  localparam logic [5:0] FnAdd  = 6'h20;
  localparam logic [5:0] FnAddu = 6'h21;
  localparam logic [5:0] FnSlt  = 6'h2A;

  localparam logic [DataW-1:0] SyscallWord = 32'h0000_000C;
  localparam logic [DataW-1:0] PcRegionMask = 32'hF000_0000;

  // Data access kinds.
  localparam logic [1:0] AccNone  = 2'd0;
  localparam logic [1:0] AccLoad  = 2'd1;
  localparam logic [1:0] AccStore = 2'd2;

  typedef struct packed {
    logic [31:0] instruction_word;
    logic        memory_hit;
    logic [31:0] load_data;
  } in_req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [31:0] mem_address;
    logic [31:0] store_value;
    logic [1:0]  access_kind;
    logic        completed;
    logic        halted;
  } out_req_t;

endpackage

// File: hw/rtl/mse_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered reads.
// Stand-alone; no package dependencies.
module mse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0]         rdata_a,
  output logic [Width-1:0]         rdata_b
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports return the contents before a same-edge write.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hw/rtl/mips_subset_instruction_executor_core.sv
// Top level of the MIPS integer-subset execute core: register file in RAM,
// program counter, decode, execute and write-back. Uses mse_pkg and mse_ram.
//
//   Channel  Ports                           Moves
//   input    in_valid, in_stall, in_req      instruction word, hit flag, load data
//   result   out_valid, out_stall, out_req   next pc, access info, status
//   config   cfg_we, cfg_index, cfg_wdata    start_pc, stack_top writes
//
// One request per cycle is accepted while in_stall is low; at the accepting
// edge the register file is read and the request enters the read stage,
// and execute writes its result into the output register once that is free.
// The register file RAM reads through a register; a write at the same edge
// as a read is forwarded through a bypass register.
// Reset is synchronous and clears the register file through per-entry
// valid bits. A stall on the result side holds the execute stage and
// then stalls the input side.
module mips_subset_instruction_executor_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mse_pkg::in_req_t                in_req,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mse_pkg::out_req_t               out_req,
  input  logic                            cfg_we,
  input  logic [mse_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [mse_pkg::DataW-1:0]       cfg_wdata
);

  logic                            in_accept;
  logic                            s1_advance;
  logic                            s1_valid_r;
  mse_pkg::in_req_t                s1_req_r;
  logic                            s1_vld_a_r;
  logic                            s1_vld_b_r;
  logic [mse_pkg::NumRegs-1:0]     reg_vld_r;
  logic                            byp_v_r;
  logic [mse_pkg::RegAddrW-1:0]    byp_addr_r;
  logic [mse_pkg::DataW-1:0]       byp_data_r;
  logic [mse_pkg::DataW-1:0]       pc_r;
  logic                            out_valid_r;
  mse_pkg::out_req_t               out_req_r;

  logic [mse_pkg::RegAddrW-1:0]    rd_addr_a;
  logic [mse_pkg::RegAddrW-1:0]    rd_addr_b;
  logic [mse_pkg::DataW-1:0]       ram_rdata_a;
  logic [mse_pkg::DataW-1:0]       ram_rdata_b;
  logic                            ram_we;
  logic [mse_pkg::RegAddrW-1:0]    ram_waddr;
  logic [mse_pkg::DataW-1:0]       ram_wdata;
  logic                            cfg_pc_we;
  logic                            cfg_sp_we;

  // Decoded fields of the instruction in the execute stage.
  logic [5:0]                      opcode;
  logic [5:0]                      funct;
  logic [mse_pkg::RegAddrW-1:0]    rs;
  logic [mse_pkg::RegAddrW-1:0]    rt;
  logic [mse_pkg::RegAddrW-1:0]    rd;
  logic [4:0]                      shamt;
  logic [15:0]                     imm;
  logic [mse_pkg::DataW-1:0]       imm_sext;
  logic [mse_pkg::DataW-1:0]       opnd_a;
  logic [mse_pkg::DataW-1:0]       opnd_b;
  logic [mse_pkg::DataW-1:0]       mul_lo;
  logic [mse_pkg::DataW-1:0]       seq_pc;
  logic [mse_pkg::DataW-1:0]       jump_pc;
  logic [mse_pkg::DataW-1:0]       branch_pc;
  logic [mse_pkg::DataW-1:0]       mem_addr;

  logic                            wb_en;
  logic [mse_pkg::RegAddrW-1:0]    wb_addr;
  logic [mse_pkg::DataW-1:0]       wb_data;
  logic                            wr_en;
  logic [mse_pkg::DataW-1:0]       npc;
  logic [mse_pkg::DataW-1:0]       addr_out;
  logic [mse_pkg::DataW-1:0]       sval_out;
  logic [1:0]                      kind_out;
  logic                            done;
  logic                            halt;
  mse_pkg::out_req_t               result;

  // Handshake: the execute stage moves when the output register is free.
  assign s1_advance = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall   = s1_valid_r && !s1_advance;
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_req    = out_req_r;

  assign cfg_pc_we = cfg_we && (cfg_index == mse_pkg::CfgStartPc);
  assign cfg_sp_we = cfg_we && (cfg_index == mse_pkg::CfgStackTop);

  assign rd_addr_a = in_req.instruction_word[25:21];
  assign rd_addr_b = in_req.instruction_word[20:16];

  // Register file write port: execute write-back wins over a stack_top load.
  assign ram_we    = wr_en || cfg_sp_we;
  assign ram_waddr = wr_en ? wb_addr : mse_pkg::RegSp;
  assign ram_wdata = wr_en ? wb_data : cfg_wdata;

  mse_ram #(
    .Width (mse_pkg::DataW),
    .Depth (mse_pkg::NumRegs)
  ) u_regfile (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (in_accept),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // Read stage: capture the request, entry valid bits and the same-edge write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r   <= in_req;
      s1_vld_a_r <= reg_vld_r[rd_addr_a];
      s1_vld_b_r <= reg_vld_r[rd_addr_b];
      byp_v_r    <= ram_we;
      byp_addr_r <= ram_waddr;
      byp_data_r <= ram_wdata;
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_vld_r <= '0;
    end else if (ram_we) begin
      reg_vld_r[ram_waddr] <= 1'b1;
    end
  end

  // Instruction field decode.
  assign opcode   = s1_req_r.instruction_word[31:26];
  assign rs       = s1_req_r.instruction_word[25:21];
  assign rt       = s1_req_r.instruction_word[20:16];
  assign rd       = s1_req_r.instruction_word[15:11];
  assign shamt    = s1_req_r.instruction_word[10:6];
  assign funct    = s1_req_r.instruction_word[5:0];
  assign imm      = s1_req_r.instruction_word[15:0];
  assign imm_sext = {{16{imm[15]}}, imm};

  // Operands: forwarded write, RAM data, or zero for an unwritten entry.
  assign opnd_a = (byp_v_r && (byp_addr_r == rs)) ? byp_data_r :
                  (s1_vld_a_r ? ram_rdata_a : '0);
  assign opnd_b = (byp_v_r && (byp_addr_r == rt)) ? byp_data_r :
                  (s1_vld_b_r ? ram_rdata_b : '0);

  assign mul_lo    = opnd_a * opnd_b;
  assign seq_pc    = pc_r + 32'd4;
  assign jump_pc   = (seq_pc & mse_pkg::PcRegionMask) |
                     {4'b0000, s1_req_r.instruction_word[25:0], 2'b00};
  assign branch_pc = seq_pc + {imm_sext[29:0], 2'b00};
  assign mem_addr  = opnd_a + imm_sext;

  // Execute: result value, write-back target and next program counter.
  always_comb begin
    wb_en    = 1'b0;
    wb_addr  = rt;
    wb_data  = '0;
    npc      = seq_pc;
    addr_out = '0;
    sval_out = '0;
    kind_out = mse_pkg::AccNone;
    done     = 1'b1;
    halt     = 1'b0;
    if (s1_req_r.instruction_word == mse_pkg::SyscallWord) begin
      halt = 1'b1;
    end else begin
      unique case (opcode) inside
        mse_pkg::OpSpecial: begin
          wb_addr = rd;
          unique case (funct) inside
            mse_pkg::FnAdd, mse_pkg::FnAddu: begin
              wb_en   = 1'b1;
              wb_data = opnd_a + opnd_b;
            end
            mse_pkg::FnSlt: begin
              wb_en   = 1'b1;
              wb_data = {31'd0, ($signed(opnd_a) < $signed(opnd_b))};
            end
            mse_pkg::FnSll: begin
              wb_en   = 1'b1;
              wb_data = opnd_b << shamt;
            end
            mse_pkg::FnJr: begin
              npc = opnd_a;
            end
            default: begin
            end
          endcase
        end
        mse_pkg::OpAddi, mse_pkg::OpAddiu: begin
          wb_en   = 1'b1;
          wb_data = opnd_a + imm_sext;
        end
        mse_pkg::OpOri: begin
          wb_en   = 1'b1;
          wb_data = opnd_a | {16'd0, imm};
        end
        mse_pkg::OpLui: begin
          wb_en   = 1'b1;
          wb_data = {imm, 16'd0};
        end
        mse_pkg::OpLw: begin
          addr_out = mem_addr;
          kind_out = mse_pkg::AccLoad;
          wb_en    = s1_req_r.memory_hit;
          wb_data  = s1_req_r.load_data;
          done     = s1_req_r.memory_hit;
        end
        mse_pkg::OpSw: begin
          addr_out = mem_addr;
          kind_out = mse_pkg::AccStore;
          sval_out = opnd_b;
          done     = s1_req_r.memory_hit;
        end
        mse_pkg::OpBeq: begin
          if (opnd_a == opnd_b) begin
            npc = branch_pc;
          end
        end
        mse_pkg::OpBne: begin
          if (opnd_a != opnd_b) begin
            npc = branch_pc;
          end
        end
        mse_pkg::OpJ: begin
          npc = jump_pc;
        end
        mse_pkg::OpJal: begin
          wb_en   = 1'b1;
          wb_addr = mse_pkg::RegRa;
          wb_data = seq_pc;
          npc     = jump_pc;
        end
        mse_pkg::OpSpecial2: begin
          wb_addr = rd;
          if (funct == mse_pkg::FnMul) begin
            wb_en   = 1'b1;
            wb_data = mul_lo;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Register zero is never written.
  assign wr_en = s1_advance && wb_en && (wb_addr != mse_pkg::RegZero);

  assign result.next_pc     = done ? npc : pc_r;
  assign result.mem_address = addr_out;
  assign result.store_value = sval_out;
  assign result.access_kind = kind_out;
  assign result.completed   = done;
  assign result.halted      = halt;

  // Program counter: loaded by configuration, advanced by retired requests.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else if (cfg_pc_we) begin
      pc_r <= cfg_wdata;
    end else if (s1_advance && done) begin
      pc_r <= npc;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_req_r <= result;
    end
  end

endmodule

// File: tb/tb_mips_subset_instruction_executor_core.sv
// Self-checking testbench for mips_subset_instruction_executor_core.
// Drives instruction requests and configuration writes, and checks every result
// against an in-bench instruction-level predictor or a typed-in expectation. Depends on mse_pkg and the RTL.
module tb_mips_subset_instruction_executor_core;
  timeunit 1ns;
  timeprecision 1ps;

  // One row of the directed stimulus table.
  typedef struct {
    mse_pkg::in_req_t  req;
    bit                has_typed;
    mse_pkg::out_req_t typed;
  } dir_row_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  mse_pkg::in_req_t                  in_req;
  logic                              out_valid;
  logic                              out_stall;
  mse_pkg::out_req_t                 out_req;
  logic                              cfg_we;
  logic [mse_pkg::CfgIdxW-1:0]       cfg_index;
  logic [mse_pkg::DataW-1:0]         cfg_wdata;

  // Architectural state tracked by the predictor.
  logic [mse_pkg::DataW-1:0]         arch_regs [mse_pkg::NumRegs];
  logic [mse_pkg::DataW-1:0]         arch_pc;
  logic [mse_pkg::DataW-1:0]         start_pc_q;
  logic [mse_pkg::DataW-1:0]         stack_top_q;

  mse_pkg::out_req_t                 pending_results[$];
  dir_row_t                          directed_rows[$];

  // Typed expectation that rides along with the request being offered.
  bit                                typed_valid;
  mse_pkg::out_req_t                 typed_result;

  int                                errors;
  int                                accepted_count;
  int                                gap_pct;
  bit                                quiet;

  mips_subset_instruction_executor_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #3_000_000;
    $display("tb_mips_subset_instruction_executor_core: done, errors");
    $finish;
  end

  // Instruction encoders.
  function automatic logic [31:0] enc_r(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sh, logic [5:0] fn);
    return {op, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_j(logic [5:0] op, logic [25:0] target);
    return {op, target};
  endfunction

  function automatic void set_reg(logic [4:0] idx, logic [mse_pkg::DataW-1:0] value);
    if (idx != mse_pkg::RegZero) arch_regs[idx] = value;
  endfunction

  // Executes one instruction against the tracked state and returns its result.
  function automatic mse_pkg::out_req_t predict_step(mse_pkg::in_req_t req);
    logic [31:0]       word;
    logic [5:0]        opcode;
    logic [5:0]        funct;
    logic [4:0]        rs, rt, rd, shamt;
    logic [31:0]       simm;
    logic [31:0]       seq_pc;
    logic [31:0]       target_pc;
    logic [31:0]       a, b;
    mse_pkg::out_req_t res;
    word      = req.instruction_word;
    opcode    = word[31:26];
    rs        = word[25:21];
    rt        = word[20:16];
    rd        = word[15:11];
    shamt     = word[10:6];
    funct     = word[5:0];
    simm      = {{16{word[15]}}, word[15:0]};
    seq_pc    = arch_pc + 32'd4;
    target_pc = seq_pc;
    a         = arch_regs[rs];
    b         = arch_regs[rt];
    res       = '0;
    res.access_kind = mse_pkg::AccNone;
    res.completed   = 1'b1;

    if (word == mse_pkg::SyscallWord) begin
      res.halted = 1'b1;
    end else begin
      case (opcode)
        mse_pkg::OpSpecial: begin
          if (funct == mse_pkg::FnAdd || funct == mse_pkg::FnAddu) set_reg(rd, a + b);
          else if (funct == mse_pkg::FnSlt)
            set_reg(rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
          else if (funct == mse_pkg::FnSll) set_reg(rd, b << shamt);
          else if (funct == mse_pkg::FnJr) target_pc = a;
        end
        mse_pkg::OpAddi, mse_pkg::OpAddiu: set_reg(rt, a + simm);
        mse_pkg::OpOri: set_reg(rt, a | {16'h0, word[15:0]});
        mse_pkg::OpLui: set_reg(rt, {word[15:0], 16'h0});
        mse_pkg::OpLw: begin
          res.mem_address = a + simm;
          res.access_kind = mse_pkg::AccLoad;
          if (req.memory_hit) set_reg(rt, req.load_data);
          else res.completed = 1'b0;
        end
        mse_pkg::OpSw: begin
          res.mem_address = a + simm;
          res.access_kind = mse_pkg::AccStore;
          res.store_value = b;
          if (!req.memory_hit) res.completed = 1'b0;
        end
        mse_pkg::OpBeq: if (a == b) target_pc = seq_pc + (simm << 2);
        mse_pkg::OpBne: if (a != b) target_pc = seq_pc + (simm << 2);
        mse_pkg::OpJ:
          target_pc = (seq_pc & mse_pkg::PcRegionMask) | {4'h0, word[25:0], 2'b00};
        mse_pkg::OpJal: begin
          arch_regs[mse_pkg::RegRa] = seq_pc;
          target_pc = (seq_pc & mse_pkg::PcRegionMask) | {4'h0, word[25:0], 2'b00};
        end
        mse_pkg::OpSpecial2: if (funct == mse_pkg::FnMul) set_reg(rd, a * b);
        default: ;
      endcase
    end

    if (res.completed) arch_pc = target_pc;
    res.next_pc = arch_pc;
    return res;
  endfunction

  task automatic compare_result(mse_pkg::out_req_t exp, mse_pkg::out_req_t got);
    if (got.next_pc !== exp.next_pc) begin
      $error("next_pc: expected %h, got %h", exp.next_pc, got.next_pc);
      errors++;
    end
    if (got.mem_address !== exp.mem_address) begin
      $error("mem_address: expected %h, got %h", exp.mem_address, got.mem_address);
      errors++;
    end
    if (got.store_value !== exp.store_value) begin
      $error("store_value: expected %h, got %h", exp.store_value, got.store_value);
      errors++;
    end
    if (got.access_kind !== exp.access_kind) begin
      $error("access_kind: expected %0d, got %0d", exp.access_kind, got.access_kind);
      errors++;
    end
    if (got.completed !== exp.completed) begin
      $error("completed: expected %b, got %b", exp.completed, got.completed);
      errors++;
    end
    if (got.halted !== exp.halted) begin
      $error("halted: expected %b, got %b", exp.halted, got.halted);
      errors++;
    end
  endtask

  // Result checking first, then configuration and accepted requests update
  // the predictor. A result never shares an edge with its own request.
  always @(posedge clk) begin
    mse_pkg::out_req_t exp;
    mse_pkg::out_req_t predicted;
    if (!rst_n) begin
      foreach (arch_regs[i]) arch_regs[i] = '0;
      start_pc_q  = '0;
      stack_top_q = '0;
      arch_regs[mse_pkg::RegSp] = stack_top_q;
      arch_pc = start_pc_q;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: next_pc %h", out_req.next_pc);
          errors++;
        end else begin
          exp = pending_results.pop_front();
          compare_result(exp, out_req);
        end
      end
      if (cfg_we) begin
        if (cfg_index == mse_pkg::CfgStartPc) begin
          start_pc_q = cfg_wdata;
          arch_pc    = cfg_wdata;
        end else begin
          stack_top_q               = cfg_wdata;
          arch_regs[mse_pkg::RegSp] = cfg_wdata;
        end
      end
      if (in_valid && !in_stall) begin
        predicted = predict_step(in_req);
        pending_results = {pending_results, (typed_valid ? typed_result : predicted)};
        accepted_count++;
      end
    end
  end

  // Result-side back-pressure: short random bursts, plus one long hold-off
  // so that the core fills up and stalls its input.
  initial begin
    int  stall_left;
    bit  long_hold_done;
    stall_left     = 0;
    long_hold_done = 1'b0;
    out_stall      = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (!long_hold_done && accepted_count >= 600) begin
          stall_left     = 200;
          long_hold_done = 1'b1;
        end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
          stall_left = $urandom_range(1, 14);
        end
      end
      out_stall = (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  function automatic logic [4:0] pick_reg();
    case ($urandom_range(0, 9))
      0: return mse_pkg::RegZero;
      1: return mse_pkg::RegSp;
      2: return mse_pkg::RegRa;
      3, 4, 5: return 5'($urandom_range(1, 3));
      default: return 5'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Mostly well-formed instructions, their registers mostly from a small pool,
  // with some raw words, syscalls and near-syscall encodings mixed in.
  function automatic mse_pkg::in_req_t random_request();
    mse_pkg::in_req_t req;
    logic [4:0]       rs, rt, rd, sh;
    logic [15:0]      imm;
    int unsigned      pick;
    rs   = pick_reg();
    rt   = pick_reg();
    rd   = pick_reg();
    sh   = 5'($urandom());
    imm  = pick_imm();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      req.instruction_word = $urandom();
    end else if (pick < 11) begin
      req.instruction_word = mse_pkg::SyscallWord;
    end else if (pick < 13) begin
      req.instruction_word = mse_pkg::SyscallWord ^ (32'h1 << $urandom_range(0, 31));
    end else begin
      case ($urandom_range(0, 15))
        0:  req.instruction_word = enc_r(mse_pkg::OpSpecial, rs, rt, rd, sh, mse_pkg::FnAdd);
        1:  req.instruction_word = enc_r(mse_pkg::OpSpecial, rs, rt, rd, sh, mse_pkg::FnAddu);
        2:  req.instruction_word = enc_r(mse_pkg::OpSpecial, rs, rt, rd, sh, mse_pkg::FnSlt);
        3:  req.instruction_word = enc_r(mse_pkg::OpSpecial, rs, rt, rd, sh, mse_pkg::FnSll);
        4:  req.instruction_word = enc_r(mse_pkg::OpSpecial, rs, rt, rd, sh, mse_pkg::FnJr);
        5:  req.instruction_word = enc_i(mse_pkg::OpAddi, rs, rt, imm);
        6:  req.instruction_word = enc_i(mse_pkg::OpAddiu, rs, rt, imm);
        7:  req.instruction_word = enc_i(mse_pkg::OpOri, rs, rt, imm);
        8:  req.instruction_word = enc_i(mse_pkg::OpLui, rs, rt, imm);
        9:  req.instruction_word = enc_i(mse_pkg::OpLw, rs, rt, imm);
        10: req.instruction_word = enc_i(mse_pkg::OpSw, rs, rt, imm);
        11: req.instruction_word = enc_i(mse_pkg::OpBeq, rs, rt, imm);
        12: req.instruction_word = enc_i(mse_pkg::OpBne, rs, rt, imm);
        13: req.instruction_word = enc_j(mse_pkg::OpJ, {rs, rt, imm});
        14: req.instruction_word = enc_j(mse_pkg::OpJal, {rs, rt, imm});
        default:
          req.instruction_word = enc_r(mse_pkg::OpSpecial2, rs, rt, rd, sh, mse_pkg::FnMul);
      endcase
    end
    req.memory_hit = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 7) == 0) req.load_data = $urandom_range(0, 1) ? '1 : '0;
    else req.load_data = $urandom();
    return req;
  endfunction

  // Offers one request, with an optional idle gap first, and returns at the
  // falling edge after it was accepted.
  task automatic send_request(mse_pkg::in_req_t req, bit has_typed,
                              mse_pkg::out_req_t typed);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_req       = req;
    typed_valid  = has_typed;
    typed_result = typed;
    in_valid     = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering and waits until every result is back and the pipe is empty.
  task automatic wait_idle();
    in_valid    = 1'b0;
    typed_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes both configuration registers on consecutive cycles.
  task automatic program_core(logic [mse_pkg::DataW-1:0] pc_value,
                              logic [mse_pkg::DataW-1:0] sp_value);
    cfg_we    = 1'b1;
    cfg_index = mse_pkg::CfgStartPc;
    cfg_wdata = pc_value;
    @(negedge clk);
    cfg_index = mse_pkg::CfgStackTop;
    cfg_wdata = sp_value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Appends a table row that is checked against the predictor.
  function automatic void add_row(logic [31:0] word, logic hit, logic [31:0] ldata);
    dir_row_t row;
    row.req.instruction_word = word;
    row.req.memory_hit       = hit;
    row.req.load_data        = ldata;
    row.has_typed            = 1'b0;
    row.typed                = '0;
    directed_rows = {directed_rows, row};
  endfunction

  // Appends a table row with its expected result typed in.
  function automatic void add_typed(logic [31:0] word, logic hit, logic [31:0] ldata,
                                    mse_pkg::out_req_t typed);
    dir_row_t row;
    row.req.instruction_word = word;
    row.req.memory_hit       = hit;
    row.req.load_data        = ldata;
    row.has_typed            = 1'b1;
    row.typed                = typed;
    directed_rows = {directed_rows, row};
  endfunction

  // Directed table: reset values, field extremes, every operation, misses,
  // register zero writes, halting and unknown encodings.
  task automatic build_directed();
    add_typed(enc_r(mse_pkg::OpSpecial, 5'd0, 5'd0, 5'd0, 5'd0, mse_pkg::FnSll),
              1'b0, 32'h0, '{32'h4, 32'h0, 32'h0, mse_pkg::AccNone, 1'b1, 1'b0});
    add_typed(mse_pkg::SyscallWord, 1'b1, 32'hFFFF_FFFF,
              '{32'h8, 32'h0, 32'h0, mse_pkg::AccNone, 1'b1, 1'b1});
    add_row(enc_i(mse_pkg::OpLui, 5'd0, 5'd1, 16'hFFFF), 1'b0, 32'h0);
    add_row(enc_i(mse_pkg::OpOri, 5'd1, 5'd1, 16'hFFFF), 1'b1, 32'h0);
    add_row(enc_i(mse_pkg::OpAddiu, 5'd0, 5'd2, 16'h0001), 1'b0, 32'h0);
    add_row(enc_r(mse_pkg::OpSpecial, 5'd1, 5'd2, 5'd3, 5'd0, mse_pkg::FnAdd), 1'b0, 32'h0);
    add_row(enc_i(mse_pkg::OpAddi, 5'd0, 5'd4, 16'h8000), 1'b0, 32'h0);
    add_row(enc_r(mse_pkg::OpSpecial, 5'd4, 5'd4, 5'd5, 5'd0, mse_pkg::FnAddu), 1'b0, 32'h0);
    add_row(enc_r(mse_pkg::OpSpecial, 5'd1, 5'd2, 5'd6, 5'd0, mse_pkg::FnSlt), 1'b0, 32'h0);
    add_row(enc_r(mse_pkg::OpSpecial, 5'd2, 5'd1, 5'd7, 5'd0, mse_pkg::FnSlt), 1'b0, 32'h0);
    add_row(enc_r(mse_pkg::OpSpecial, 5'd0, 5'd1, 5'd7, 5'd31, mse_pkg::FnSll), 1'b0, 32'h0);
    add_row(enc_r(mse_pkg::OpSpecial2, 5'd1, 5'd4, 5'd8, 5'd0, mse_pkg::FnMul), 1'b0, 32'h0);
    // A write to register zero must be dropped.
    add_row(enc_i(mse_pkg::OpAddiu, 5'd0, 5'd0, 16'h0005), 1'b0, 32'h0);
    // Store miss: the address and data show, the pc holds at 0x34.
    add_typed(enc_i(mse_pkg::OpSw, 5'd0, 5'd1, 16'hFFFC), 1'b0, 32'h0,
              '{32'h34, 32'hFFFF_FFFC, 32'hFFFF_FFFF, mse_pkg::AccStore, 1'b0, 1'b0});
    add_row(enc_i(mse_pkg::OpSw, 5'd0, 5'd1, 16'hFFFC), 1'b1, 32'h0);
    add_row(enc_i(mse_pkg::OpLw, 5'd2, 5'd9, 16'h7FFC), 1'b0, 32'hDEAD_BEEF);
    add_row(enc_i(mse_pkg::OpLw, 5'd2, 5'd9, 16'h7FFC), 1'b1, 32'hFFFF_FFFF);
    add_row(enc_i(mse_pkg::OpLw, 5'd0, 5'd0, 16'h0000), 1'b1, 32'hFFFF_FFFF);
    add_row(enc_i(mse_pkg::OpBeq, 5'd0, 5'd0, 16'hFFFF), 1'b0, 32'h0);
    add_row(enc_i(mse_pkg::OpBne, 5'd1, 5'd2, 16'h7FFF), 1'b0, 32'h0);
    add_row(enc_i(mse_pkg::OpBeq, 5'd1, 5'd2, 16'h0005), 1'b0, 32'h0);
    add_row(enc_j(mse_pkg::OpJal, 26'h3FF_FFFF), 1'b0, 32'h0);
    add_row(enc_r(mse_pkg::OpSpecial, 5'd31, 5'd0, 5'd0, 5'd0, mse_pkg::FnJr), 1'b0, 32'h0);
    add_row(enc_j(mse_pkg::OpJ, 26'h0), 1'b0, 32'h0);
    // Unknown encodings behave as no-ops, whatever the hit flag says.
    add_row(32'hFC00_0000, 1'b1, 32'h1234_5678);
    add_row(enc_r(mse_pkg::OpSpecial2, 5'd1, 5'd1, 5'd10, 5'd0, mse_pkg::FnAdd), 1'b0, 32'h0);
    add_row(mse_pkg::SyscallWord ^ 32'h0000_1000, 1'b0, 32'h0);
  endtask

  // Main sequence: reset, directed table, then randomized phases with a
  // fresh configuration each.
  initial begin
    logic [mse_pkg::DataW-1:0] pc_values [5];
    logic [mse_pkg::DataW-1:0] sp_values [5];
    int                        items_per_phase;
    mse_pkg::out_req_t         none;
    none           = '0;
    errors         = 0;
    accepted_count = 0;
    gap_pct        = 15;
    quiet          = 1'b0;
    typed_valid    = 1'b0;
    typed_result   = '0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req         = '0;
    cfg_we         = 1'b0;
    cfg_index      = mse_pkg::CfgStartPc;
    cfg_wdata      = '0;
    items_per_phase = 320;

    pc_values[0] = 32'hFFFF_FFFC;  sp_values[0] = 32'hFFFF_FFFF;
    pc_values[1] = 32'h0000_0000;  sp_values[1] = 32'h0000_0000;
    pc_values[2] = $urandom();     sp_values[2] = $urandom();
    pc_values[3] = 32'h8000_0000;  sp_values[3] = 32'h7FFF_FFFF;
    pc_values[4] = $urandom();     sp_values[4] = $urandom();

    build_directed();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part runs on the reset configuration.
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].has_typed, directed_rows[i].typed);
    end
    wait_idle();

    for (int phase = 0; phase < 5; phase++) begin
      program_core(pc_values[phase], sp_values[phase]);
      case (phase)
        0: gap_pct = 0;
        1: gap_pct = 10;
        2: gap_pct = 30;
        default: gap_pct = 15;
      endcase
      for (int k = 0; k < items_per_phase; k++) begin
        if (phase == 4 && k == items_per_phase - 200) quiet = 1'b1;
        send_request(random_request(), 1'b0, none);
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_mips_subset_instruction_executor_core: done, clean");
    end else begin
      $display("tb_mips_subset_instruction_executor_core: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/mse_pkg.sv
hw/rtl/mse_ram.sv
hw/rtl/mips_subset_instruction_executor_core.sv
tb/tb_mips_subset_instruction_executor_core.sv
